// ----- rtl/core/rgbhsl_pkg.sv -----
// Shared types and constants of the RGB to HSL converter.
// Used by rgbhsl_front and rgb_to_hsl_converter; depends on nothing.
`default_nettype none

package rgbhsl_pkg;

    // Pixel and result field widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;

    // Divider operand widths
    localparam int HUE_NUM_W = 18;   // 2*num + d, at most 183855
    localparam int SAT_NUM_W = 16;   // 200*d + sat_base, at most 51255
    localparam int DIV_DEN_W = 9;    // twice the divisor, at most 510
    localparam int QUO_W     = 9;    // quotient bits, hue reaches 360
    localparam int STEP_BITS = 3;    // quotient bits resolved per stage

    // Lightness: floor(x / 102) with x = 20*sum + 51, through a reciprocal
    localparam int LIG_X_W    = 14;
    localparam int LIG_RCP_W  = 10;
    localparam int LIG_PROD_W = LIG_X_W + LIG_RCP_W;
    localparam int LIG_SHIFT  = 16;
    localparam logic [LIG_RCP_W-1:0] LIG_RECIP = 10'd642;
    localparam logic [LIG_X_W-1:0]   LIG_DIV   = 14'd102;

    // Hue sector of the largest channel
    localparam logic [1:0] SEC_RED_UP   = 2'd0;
    localparam logic [1:0] SEC_RED_DOWN = 2'd1;
    localparam logic [1:0] SEC_GREEN    = 2'd2;
    localparam logic [1:0] SEC_BLUE     = 2'd3;

    // Operands handed from the front end to the dividers and lightness path
    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        logic [LIG_X_W-1:0]   lig_x;
        logic                 gray;
    } front_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgb_to_hsl_converter.sv -----
// Top level of the RGB to HSL converter: front end, two dividers, lightness path.
// Depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_div.
// Depth: 6 register stages (2 front, 3 divider, 1 output); hsl_valid is the last valid bit.
// Throughput: one pixel per clock while no result is held; the 3-bit-per-stage dividers set the depth.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module rgb_to_hsl_converter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] red,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] green,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] blue,
    output logic                               hsl_valid,
    input  wire logic                          hsl_stall,
    output logic      [rgbhsl_pkg::HUE_W-1:0]  hue,
    output logic      [rgbhsl_pkg::PCT_W-1:0]  saturation,
    output logic      [rgbhsl_pkg::PCT_W-1:0]  lightness
);

    import rgbhsl_pkg::*;

    localparam int DEPTH = 6;

    logic                  en;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    front_t                ops;
    logic [QUO_W-1:0]      hue_quo, sat_quo;

    logic [LIG_X_W-1:0]    lig_x_reg;
    logic [LIG_PROD_W-1:0] lig_prod_reg, lig_prod_next;
    logic [PCT_W-1:0]      lig_fix_reg, lig_fix_next, lig_dly_reg;
    logic [PCT_W-1:0]      lig_q0;
    logic [LIG_X_W-1:0]    lig_rem;
    logic [2:0]            gray_reg;

    logic [HUE_W-1:0]      hue_reg, hue_next;
    logic [PCT_W-1:0]      sat_reg, sat_next;
    logic [PCT_W-1:0]      lig_reg;

    // Advance the pipeline unless a finished word is held at the output
    assign en          = !(valid_reg[DEPTH-1] && hsl_stall);
    assign pixel_stall = !en;

    // Valid bits travel with the data
    assign valid_next = {valid_reg[DEPTH-2:0], pixel_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    rgbhsl_front u_front (
        .clk   (clk),
        .en    (en),
        .red   (red),
        .green (green),
        .blue  (blue),
        .ops   (ops)
    );

    rgbhsl_div #(
        .NUM_W     (HUE_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .QUO_W     (QUO_W),
        .STEP_BITS (STEP_BITS)
    ) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (ops.hue_num),
        .den (ops.hue_den),
        .quo (hue_quo)
    );

    rgbhsl_div #(
        .NUM_W     (SAT_NUM_W),
        .DEN_W     (DIV_DEN_W),
        .QUO_W     (QUO_W),
        .STEP_BITS (STEP_BITS)
    ) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (ops.sat_num),
        .den (ops.sat_den),
        .quo (sat_quo)
    );

    // Lightness: estimate x/102 by reciprocal, then fix the one-off underestimate
    assign lig_prod_next = LIG_PROD_W'(ops.lig_x) * LIG_PROD_W'(LIG_RECIP);
    assign lig_q0        = lig_prod_reg[LIG_SHIFT +: PCT_W];
    assign lig_rem       = lig_x_reg - LIG_X_W'(lig_q0) * LIG_DIV;
    assign lig_fix_next  = (lig_rem >= LIG_DIV) ? lig_q0 + 7'd1 : lig_q0;

    // Drop hue and saturation for gray pixels
    assign hue_next = gray_reg[2] ? '0 : hue_quo;
    assign sat_next = gray_reg[2] ? '0 : sat_quo[PCT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lig_x_reg    <= ops.lig_x;
            lig_prod_reg <= lig_prod_next;
            lig_fix_reg  <= lig_fix_next;
            lig_dly_reg  <= lig_fix_reg;
            gray_reg     <= {gray_reg[1:0], ops.gray};
            hue_reg      <= hue_next;
            sat_reg      <= sat_next;
            lig_reg      <= lig_dly_reg;
        end
    end

    assign hsl_valid  = valid_reg[DEPTH-1];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = lig_reg;

    // Results stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> (hue <= 9'd360 && saturation <= 7'd100 && lightness <= 7'd100))
        else $error("result out of range");

    // An accepted pixel occupies the first stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> valid_reg[0])
        else $error("accepted pixel lost at entry");

    // A held output freezes every valid bit in the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && hsl_stall |=> $stable(valid_reg))
        else $error("pipeline moved while output held");

    // A result leaves only if a word sat in the stage before the output when the pipeline last advanced
    assert property (@(posedge clk) disable iff (!rst_n)
        en && !valid_reg[DEPTH-2] |=> !hsl_valid)
        else $error("result without a word behind it");

endmodule

`default_nettype wire

// ----- rtl/core/rgbhsl_div.sv -----
// Pipelined restoring divider, STEP_BITS quotient bits per register stage.
// Stand-alone; the quotient must fit in QUO_W bits.
`default_nettype none

module rgbhsl_div #(
    parameter int NUM_W     = 18,
    parameter int DEN_W     = 9,
    parameter int QUO_W     = 9,
    parameter int STEP_BITS = 3
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int REM_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int NSTAGE = (QUO_W + STEP_BITS - 1) / STEP_BITS;

    wire  [REM_W-1:0] stage_rem [NSTAGE];
    wire  [DEN_W-1:0] stage_den [NSTAGE];
    wire  [QUO_W-1:0] stage_quo [NSTAGE];

    logic [REM_W-1:0] rem_next [NSTAGE];
    logic [QUO_W-1:0] quo_next [NSTAGE];
    logic [REM_W-1:0] rem_reg  [NSTAGE];
    logic [DEN_W-1:0] den_reg  [NSTAGE];
    logic [QUO_W-1:0] quo_reg  [NSTAGE];

    // Feed each stage from the ports or from the stage before
    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_feed
        if (s == 0)
        begin : g_first
            assign stage_rem[s] = REM_W'(num);
            assign stage_den[s] = den;
            assign stage_quo[s] = '0;
        end
        else
        begin : g_rest
            assign stage_rem[s] = rem_reg[s-1];
            assign stage_den[s] = den_reg[s-1];
            assign stage_quo[s] = quo_reg[s-1];
        end
    end

    // Resolve quotient bits from the top down, subtracting the shifted divisor
    always_comb
    begin : div_steps
        logic [REM_W-1:0] rem_v;
        logic [QUO_W-1:0] quo_v;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < NSTAGE; s++)
        begin
            rem_v = stage_rem[s];
            quo_v = stage_quo[s];
            trial = '0;
            for (int b = 0; b < STEP_BITS; b++)
            begin
                if (s * STEP_BITS + b < QUO_W)
                begin
                    trial = REM_W'(stage_den[s]) << (QUO_W - 1 - s * STEP_BITS - b);
                    if (rem_v >= trial)
                    begin
                        rem_v = rem_v - trial;
                        quo_v[QUO_W - 1 - s * STEP_BITS - b] = 1'b1;
                    end
                end
            end
            rem_next[s] = rem_v;
            quo_next[s] = quo_v;
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= stage_den[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo = quo_reg[NSTAGE-1];

endmodule

`default_nettype wire

// ----- rtl/core/rgbhsl_front.sv -----
// Front end: channel extrema and sector, then divider operands and lightness term.
// Two register stages; depends on rgbhsl_pkg.
`default_nettype none

module rgbhsl_front (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] red,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] green,
    input  wire logic [rgbhsl_pkg::CHAN_W-1:0] blue,
    output rgbhsl_pkg::front_t                ops
);

    import rgbhsl_pkg::*;

    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;
    logic [CHAN_W-1:0] mx_reg, mn_reg;
    logic [1:0]        sector_reg;
    logic [CHAN_W-1:0] mx_next, mn_next;
    logic [1:0]        sector_next;

    front_t            ops_reg, ops_next;

    logic [CHAN_W-1:0]    d;
    logic [CHAN_W:0]      sum;
    logic [CHAN_W-1:0]    sat_base;
    logic [HUE_NUM_W-1:0] d_ext, num;

    // Find largest and smallest channel; red wins ties, then green
    always_comb
    begin
        mx_next = red;
        mn_next = red;
        if (green > mx_next) mx_next = green;
        if (blue  > mx_next) mx_next = blue;
        if (green < mn_next) mn_next = green;
        if (blue  < mn_next) mn_next = blue;
        if (mx_next == red)
            sector_next = (green >= blue) ? SEC_RED_UP : SEC_RED_DOWN;
        else if (mx_next == green)
            sector_next = SEC_GREEN;
        else
            sector_next = SEC_BLUE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= red;
            g_reg      <= green;
            b_reg      <= blue;
            mx_reg     <= mx_next;
            mn_reg     <= mn_next;
            sector_reg <= sector_next;
        end
    end

    // Build hue numerator for the sector, saturation and lightness operands
    always_comb
    begin
        d     = mx_reg - mn_reg;
        sum   = {1'b0, mx_reg} + {1'b0, mn_reg};
        d_ext = HUE_NUM_W'(d);
        case (sector_reg)
            SEC_RED_UP:
                num = (HUE_NUM_W'(g_reg) - HUE_NUM_W'(b_reg)) * 18'd60;
            SEC_RED_DOWN:
                num = d_ext * 18'd360 - (HUE_NUM_W'(b_reg) - HUE_NUM_W'(g_reg)) * 18'd60;
            SEC_GREEN:
                num = d_ext * 18'd120 + HUE_NUM_W'(b_reg) * 18'd60
                      - HUE_NUM_W'(r_reg) * 18'd60;
            SEC_BLUE:
                num = d_ext * 18'd240 + HUE_NUM_W'(r_reg) * 18'd60
                      - HUE_NUM_W'(g_reg) * 18'd60;
            default:
                num = '0;
        endcase

        sat_base = (sum <= 9'd255) ? sum[CHAN_W-1:0] : CHAN_W'(9'd510 - sum);

        ops_next.hue_num = (num << 1) + d_ext;
        ops_next.hue_den = {d, 1'b0};
        ops_next.sat_num = SAT_NUM_W'(d) * 16'd200 + SAT_NUM_W'(sat_base);
        ops_next.sat_den = {sat_base, 1'b0};
        ops_next.lig_x   = LIG_X_W'(sum) * 14'd20 + 14'd51;
        ops_next.gray    = (d == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_reg <= ops_next;
        end
    end

    assign ops = ops_reg;

endmodule

`default_nettype wire
